/* rtl/core/bta_pkg.sv */
// Shared constants for the boundary-tag heap allocator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package bta_pkg;

    localparam int DEF_HEAP_BYTES = 65536;
    localparam int FIRST_HDR      = 2;
    localparam int MIN_SPLIT      = 32;
    localparam int PROLOGUE_TAG   = 17;
    localparam int EPILOGUE_TAG   = 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

/* rtl/core/bta_tag_ram.sv */
// Single-port tag memory with registered read.
// No dependencies; instantiated by the allocator top level.
`timescale 1ns / 1ps

module bta_tag_ram #(
    parameter int AW = 13,
    parameter int TW = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [TW-1:0] i_wdata,
    output logic [TW-1:0] o_rdata
);

    logic [TW-1:0] mem [2**AW];
    logic [TW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/boundary_tag_heap_allocator_top.sv */
// Boundary-tag heap allocator top level: control sequencer, rover and result register.
// Depends on bta_pkg and bta_tag_ram.
`timescale 1ns / 1ps

// Usage:
// Request channel (i_valid / o_ready) carries one word: i_op selects allocate
// (request size in i_request_bytes) or free (payload offset in i_free_address).
// Result channel (o_valid / i_ready) returns one word per request: o_success,
// o_block_address and o_granted_bytes.
// Config channel (i_cfg_valid / o_cfg_ready) writes fit_policy; always ready.
// Every tag access goes through the one port of the tag RAM, one read or
// write per cycle. Allocate reads each block header it visits, then writes
// two tag words, or four when it splits the block. Free reads the header,
// the prior footer and next header, then writes two words, or four if it merges.
// Reset: synchronous, active low. After reset a clearing pass writes every
// tag word, HEAP_BYTES/8 words (8192 by default); o_ready stays low during
// it, config writes are still taken.
// Stall: a finished result waits in the output register; the next request
// is accepted and worked on, and holds in its last step until the earlier
// result is taken.
module boundary_tag_heap_allocator_top
    import bta_pkg::*;
#(
    parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [16:0] i_request_bytes,
    input  logic [15:0] i_free_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_success,
    output logic [15:0] o_block_address,
    output logic [16:0] o_granted_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_fit_policy
);

    localparam int WORDS      = HEAP_BYTES / 8;
    localparam int AW         = $clog2(WORDS);
    localparam int TW         = $clog2(HEAP_BYTES) + 1;
    localparam int FIRST_SIZE = (HEAP_BYTES - 24) & ~15;
    localparam int EPI        = FIRST_HDR + FIRST_SIZE / 8;
    localparam int NW         = (TW > 18) ? TW : 18;
    localparam int XW         = ((AW > 13) ? AW : 13) + 2;

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_ARD  = 10'b0000000100,
        S_ACHK = 10'b0000001000,
        S_FRD  = 10'b0000010000,
        S_FH   = 10'b0000100000,
        S_FP   = 10'b0001000000,
        S_FN   = 10'b0010000000,
        S_WR   = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_fit, n_fit;
    logic [AW-1:0] r_rover, n_rover;
    logic [AW-1:0] r_h, n_h;
    logic [AW-1:0] r_start, n_start;
    logic [AW:0]   r_limit, n_limit;
    logic          r_phase2, n_phase2;
    logic [NW-1:0] r_need, n_need;
    logic [12:0]   r_fw, n_fw;
    logic [TW-1:0] r_s, n_s;
    logic          r_pfree, n_pfree;
    logic [TW-1:0] r_ps, n_ps;
    logic [AW-1:0] r_wa [4];
    logic [AW-1:0] n_wa [4];
    logic [TW-1:0] r_wd [4];
    logic [TW-1:0] n_wd [4];
    logic [2:0]    r_wcnt, n_wcnt;
    logic [1:0]    r_widx, n_widx;
    logic          r_res_ok, n_res_ok;
    logic [15:0]   r_res_addr, n_res_addr;
    logic [16:0]   r_res_gr, n_res_gr;
    logic          r_o_valid, n_o_valid;
    logic          r_o_ok, n_o_ok;
    logic [15:0]   r_o_addr, n_o_addr;
    logic [16:0]   r_o_gr, n_o_gr;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [TW-1:0] mem_wd;
    logic [TW-1:0] mem_rd;

    bta_tag_ram #(.AW(AW), .TW(TW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wd),
        .o_rdata (mem_rd)
    );

    function automatic logic [TW-1:0] init_tag(input logic [AW-1:0] a);
        logic [TW-1:0] v;
        v = '0;
        if (a == AW'(0) || a == AW'(1)) v = TW'(PROLOGUE_TAG);
        if (a == AW'(FIRST_HDR) || a == AW'(EPI - 1)) v = TW'(FIRST_SIZE);
        if (a == AW'(EPI)) v = TW'(EPILOGUE_TAG);
        return v;
    endfunction

    always_comb begin
        logic [TW-1:0] s;
        logic [AW:0]   hn;
        logic [NW-1:0] sw;
        logic [NW-1:0] rem;
        logic [AW:0]   nh;
        logic [AW:0]   ftr;
        logic [AW-1:0] rh;
        logic [17:0]   rq;
        logic [XW-1:0] fwx;
        logic [AW+1:0] nend;
        logic          nfree;
        logic [AW-1:0] st;
        logic [TW-1:0] sz;
        logic [AW:0]   send;
        logic [AW+3:0] baddr;

        n_state    = r_state;
        n_clr      = r_clr;
        n_fit      = r_fit;
        n_rover    = r_rover;
        n_h        = r_h;
        n_start    = r_start;
        n_limit    = r_limit;
        n_phase2   = r_phase2;
        n_need     = r_need;
        n_fw       = r_fw;
        n_s        = r_s;
        n_pfree    = r_pfree;
        n_ps       = r_ps;
        n_wa       = r_wa;
        n_wd       = r_wd;
        n_wcnt     = r_wcnt;
        n_widx     = r_widx;
        n_res_ok   = r_res_ok;
        n_res_addr = r_res_addr;
        n_res_gr   = r_res_gr;
        n_o_valid  = r_o_valid;
        n_o_ok     = r_o_ok;
        n_o_addr   = r_o_addr;
        n_o_gr     = r_o_gr;

        mem_we   = 1'b0;
        mem_addr = r_h;
        mem_wd   = '0;

        s     = mem_rd & ~TW'(7);
        hn    = {1'b0, r_h} + (AW + 1)'(s >> 3);
        sw    = NW'(s);
        rem   = sw - r_need;
        nh    = {1'b0, r_h} + (AW + 1)'(r_need >> 3);
        ftr   = hn - (AW + 1)'(1);
        rh    = r_rover;
        rq    = 18'(i_request_bytes) + 18'd31;
        fwx   = XW'(i_free_address[15:3]);
        nend  = '0;
        nfree = 1'b0;
        st    = r_h;
        sz    = r_s;
        send  = '0;
        baddr = (AW + 4)'({1'b0, r_h} + (AW + 1)'(1)) << 3;

        if (i_cfg_valid) begin
            n_fit = i_cfg_fit_policy;
        end

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
                mem_wd   = init_tag(r_clr);
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_res_ok   = 1'b0;
                    n_res_addr = '0;
                    n_res_gr   = '0;
                    n_fw       = i_free_address[15:3];
                    if (i_op == OP_ALLOC) begin
                        n_need = (i_request_bytes <= 17'd16) ? NW'(32)
                                                             : NW'(rq & ~18'd15);
                        if (r_fit || rh < AW'(FIRST_HDR) || rh >= AW'(EPI)) begin
                            rh = AW'(FIRST_HDR);
                        end
                        if (r_fit) begin
                            rh = AW'(FIRST_HDR);
                        end
                        n_h      = rh;
                        n_start  = rh;
                        n_limit  = (AW + 1)'(EPI);
                        n_phase2 = 1'b0;
                        n_state  = S_ARD;
                    end else begin
                        // drop frees outside the block area
                        if (fwx < XW'(FIRST_HDR + 1) || fwx > XW'(EPI)) begin
                            n_state = S_DONE;
                        end else begin
                            n_h     = AW'(fwx - XW'(1));
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_ARD: begin
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (s != '0 && !mem_rd[0] && r_need <= sw) begin
                    if (!r_fit) begin
                        n_rover = r_h;
                    end
                    n_res_ok   = 1'b1;
                    n_res_addr = 16'(baddr);
                    n_widx     = '0;
                    n_wcnt     = 3'd2;
                    n_state    = S_WR;
                    if (rem >= NW'(MIN_SPLIT)) begin
                        n_res_gr = 17'(r_need);
                        n_wcnt   = 3'd4;
                        n_wa[0]  = r_h;
                        n_wd[0]  = TW'(r_need) | TW'(1);
                        n_wa[1]  = AW'(nh - (AW + 1)'(1));
                        n_wd[1]  = TW'(r_need) | TW'(1);
                        n_wa[2]  = AW'(nh);
                        n_wd[2]  = TW'(rem);
                        n_wa[3]  = AW'(ftr);
                        n_wd[3]  = TW'(rem);
                    end else begin
                        n_res_gr = 17'(s);
                        n_wa[0]  = r_h;
                        n_wd[0]  = s | TW'(1);
                        n_wa[1]  = AW'(ftr);
                        n_wd[1]  = s | TW'(1);
                    end
                end else if (s != '0 && hn < r_limit && hn < (AW + 1)'(EPI)) begin
                    n_h     = AW'(hn);
                    n_state = S_ARD;
                end else if (!r_fit && !r_phase2 && r_start != AW'(FIRST_HDR)) begin
                    // wrap: search from the heap start up to the rover
                    n_phase2 = 1'b1;
                    n_h      = AW'(FIRST_HDR);
                    n_limit  = {1'b0, r_start};
                    n_state  = S_ARD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FRD: begin
                n_state = S_FH;
            end
            S_FH: begin
                n_s = s;
                if (s == '0 || ftr >= (AW + 1)'(EPI)) begin
                    n_state = S_DONE;
                end else begin
                    if (XW'(r_fw) <= XW'(r_rover)) begin
                        n_rover = r_h;
                    end
                    mem_addr = r_h - AW'(1);
                    n_state  = S_FP;
                end
            end
            S_FP: begin
                n_ps     = s;
                n_pfree  = !mem_rd[0] && s != '0 &&
                           (AW + 1)'(s >> 3) <= (AW + 1)'(r_h - AW'(FIRST_HDR));
                mem_addr = AW'({1'b0, r_h} + (AW + 1)'(r_s >> 3));
                n_state  = S_FN;
            end
            S_FN: begin
                nh    = {1'b0, r_h} + (AW + 1)'(r_s >> 3);
                nend  = (AW + 2)'(nh) + (AW + 2)'(s >> 3) - (AW + 2)'(1);
                nfree = nh < (AW + 1)'(EPI) && !mem_rd[0] && s != '0 &&
                        nend < (AW + 2)'(EPI);
                if (r_pfree) begin
                    st = r_h - AW'(r_ps >> 3);
                    sz = sz + r_ps;
                end
                if (nfree) begin
                    sz = sz + s;
                end
                send    = {1'b0, st} + (AW + 1)'(sz >> 3);
                n_wa[0] = r_h;
                n_wd[0] = r_s;
                n_wa[1] = AW'({1'b0, r_h} + (AW + 1)'(r_s >> 3) - (AW + 1)'(1));
                n_wd[1] = r_s;
                n_wa[2] = st;
                n_wd[2] = sz;
                n_wa[3] = AW'(send - (AW + 1)'(1));
                n_wd[3] = sz;
                n_wcnt  = (r_pfree || nfree) ? 3'd4 : 3'd2;
                if ((r_pfree || nfree) && r_rover > st && {1'b0, r_rover} < send) begin
                    n_rover = st;
                end
                n_widx   = '0;
                n_res_ok = 1'b1;
                n_state  = S_WR;
            end
            S_WR: begin
                mem_we   = 1'b1;
                mem_addr = r_wa[r_widx];
                mem_wd   = r_wd[r_widx];
                n_widx   = r_widx + 2'd1;
                if (3'(r_widx) == r_wcnt - 3'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_ok    = r_res_ok;
                    n_o_addr  = r_res_addr;
                    n_o_gr    = r_res_gr;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_fit     <= 1'b0;
            r_rover   <= AW'(FIRST_HDR);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_fit     <= n_fit;
            r_rover   <= n_rover;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h        <= n_h;
        r_start    <= n_start;
        r_limit    <= n_limit;
        r_phase2   <= n_phase2;
        r_need     <= n_need;
        r_fw       <= n_fw;
        r_s        <= n_s;
        r_pfree    <= n_pfree;
        r_ps       <= n_ps;
        r_wa       <= n_wa;
        r_wd       <= n_wd;
        r_wcnt     <= n_wcnt;
        r_widx     <= n_widx;
        r_res_ok   <= n_res_ok;
        r_res_addr <= n_res_addr;
        r_res_gr   <= n_res_gr;
        r_o_ok     <= n_o_ok;
        r_o_addr   <= n_o_addr;
        r_o_gr     <= n_o_gr;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_success       = r_o_ok;
    assign o_block_address = r_o_addr;
    assign o_granted_bytes = r_o_gr;
    assign o_cfg_ready     = 1'b1;

`ifndef SYNTHESIS
    a_rover_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rover >= AW'(FIRST_HDR) && r_rover < AW'(EPI))
        else $error("rover outside block area");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_success |-> o_block_address == '0 && o_granted_bytes == '0)
        else $error("failed result carries nonzero fields");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_ready && !mem_we || mem_addr == r_clr)
        else $error("clearing pass disturbed");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && (!o_valid || i_ready) |=> o_valid)
        else $error("finished result not presented");
`endif

endmodule
